// File: rtl/ctpf_pkg.sv
// ctpf_pkg: shared types and constants for the call trace prune filter
// holds the transaction payload structs, command codes and table sizing
// no dependencies

package ctpf_pkg;

  // table and level sizing
  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_DEPTH   = 255;
  localparam int ADDR_W      = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int LVL_W       = $clog2(MAX_DEPTH + 1);

  // fixed field widths of the transactions
  localparam int CMD_W        = 2;
  localparam int IN_ADDR_W    = 64;
  localparam int ENTRY_IDX_W  = 10;
  localparam int DEPTH_W      = 8;
  localparam int SYM_IDX_W    = 10;
  localparam int SYM_COUNT_W  = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [IN_ADDR_W-1:0]   address;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   entry_pruned;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]   depth;
    logic [SYM_IDX_W-1:0] symbol_index;
    logic                 found;
  } out_item_t;

  // one symbol table entry
  typedef struct packed {
    logic              pruned;
    logic [ADDR_W-1:0] addr;
  } sym_entry_t;

endpackage

// File: rtl/call_trace_prune_filter.sv
// call_trace_prune_filter: call depth tracking and binary search trace filter
// depends on ctpf_pkg for payload structs, command codes and sizing
//
//  port group | dir | handshake        | payload
//  -----------+-----+------------------+------------------------------
//  in_        | in  | in_valid/in_stall| in_item_t  (command, address, ...)
//  out_       | out | out_valid/out_st.| out_item_t (depth, symbol_index, found)
//  cfg_       | in  | cfg_we           | cfg_wdata  (symbol_count)
//
// load, exit and pruned-away enter transactions are handled in the idle state.
// an enter that is searched runs its probes and then a finish step; probes is at most
// floor(log2(count)) + 1, so up to 11 probes for a full 1024 entry table.
// the single-port table read gives one probe per cycle.
// rst_n is synchronous; it clears level, prune and count state, not the table.
// a result waits in the output register under out_stall while the next
// transaction is taken; the finish step only waits if that register is still full.

module call_trace_prune_filter
  import ctpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [SYM_COUNT_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SYM_COUNT_W-1:0] symbol_count_r;
  logic [LVL_W-1:0]       level_r, level_nxt;
  logic [LVL_W-1:0]       prune_level_r, prune_level_nxt;
  logic                   prune_active_r, prune_active_nxt;
  logic [ADDR_W-1:0]      key_r, key_nxt;
  logic [LVL_W-1:0]       saved_r, saved_nxt;
  logic [CNT_W-1:0]       lo_r, lo_nxt;
  logic [CNT_W-1:0]       hi_r, hi_nxt;
  logic [IDX_W-1:0]       mid_r, mid_nxt;
  logic                   hit_r, hit_nxt;
  logic                   hit_pruned_r, hit_pruned_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  sym_entry_t             table_mem [TABLE_DEPTH];
  sym_entry_t             rd_r;
  logic                   wr_en;

  logic                   in_acc;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       lo_sel, hi_sel;
  logic [CNT_W:0]         mid_sum;
  logic                   probe_eq, probe_lt;
  logic [LVL_W-1:0]       level_dec;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective entry count, clamped to the table size
  assign count = (symbol_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : symbol_count_r;

  // probe compare against the registered table read
  assign probe_eq = (rd_r.addr == key_r);
  assign probe_lt = (rd_r.addr <  key_r);

  // saturating decrement for exit
  assign level_dec = (level_r != '0) ? level_r - LVL_W'(1) : '0;

  // shared range update and midpoint: first probe from idle, next ones in search
  always_comb begin
    if (state_r == S_SEARCH) begin
      lo_sel = probe_lt ? ({1'b0, mid_r} + CNT_W'(1)) : lo_r;
      hi_sel = probe_lt ? hi_r : {1'b0, mid_r};
    end else begin
      lo_sel = '0;
      hi_sel = count;
    end
    mid_sum = {1'b0, lo_sel} + {1'b0, hi_sel} - (CNT_W+1)'(1);
  end

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    level_nxt        = level_r;
    prune_level_nxt  = prune_level_r;
    prune_active_nxt = prune_active_r;
    key_nxt          = key_r;
    saved_nxt        = saved_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    hit_nxt          = hit_r;
    hit_pruned_nxt   = hit_pruned_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    wr_en            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_LOAD: begin
              wr_en = 1'b1;
            end
            CMD_ENTER: begin
              saved_nxt = level_r;
              if (level_r < LVL_W'(MAX_DEPTH)) begin
                level_nxt = level_r + LVL_W'(1);
              end
              key_nxt        = in_data.address[ADDR_W-1:0];
              lo_nxt         = lo_sel;
              hi_nxt         = hi_sel;
              mid_nxt        = mid_sum[IDX_W:1];
              hit_nxt        = 1'b0;
              hit_pruned_nxt = 1'b0;
              if (!(prune_active_r && level_r > prune_level_r)) begin
                state_nxt = (count == '0) ? S_FINISH : S_SEARCH;
              end
            end
            CMD_EXIT: begin
              level_nxt = level_dec;
              if (prune_active_r && level_dec == prune_level_r) begin
                prune_active_nxt = 1'b0;
                prune_level_nxt  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (probe_eq) begin
          hit_nxt        = 1'b1;
          hit_pruned_nxt = rd_r.pruned;
          state_nxt      = S_FINISH;
        end else begin
          lo_nxt  = lo_sel;
          hi_nxt  = hi_sel;
          mid_nxt = mid_sum[IDX_W:1];
          if (lo_sel >= hi_sel) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (hit_r && hit_pruned_r) begin
          prune_level_nxt  = saved_r;
          prune_active_nxt = 1'b1;
          state_nxt        = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.depth        = DEPTH_W'(saved_r);
          out_data_nxt.symbol_index = hit_r ? SYM_IDX_W'(mid_r) : '0;
          out_data_nxt.found        = hit_r;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      level_r        <= '0;
      prune_level_r  <= '0;
      prune_active_r <= 1'b0;
      symbol_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      level_r        <= level_nxt;
      prune_level_r  <= prune_level_nxt;
      prune_active_r <= prune_active_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        symbol_count_r <= cfg_wdata;
      end
    end
  end

  // search and result payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    saved_r      <= saved_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    hit_r        <= hit_nxt;
    hit_pruned_r <= hit_pruned_nxt;
    out_data_r   <= out_data_nxt;
  end

  // symbol table: one write port for loads, one registered read at the next probe
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[in_data.entry_index[IDX_W-1:0]] <= '{pruned: in_data.entry_pruned,
                                                    addr: in_data.address[ADDR_W-1:0]};
    end
    rd_r <= table_mem[mid_nxt];
  end

`ifndef NO_ASSERTIONS
  // a searched range is never empty
  a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (lo_r < hi_r))
    else $error("search range empty while probing");

  // the level stays within its limit
  a_level_limit: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(MAX_DEPTH))
    else $error("nesting level above limit");

  // an inactive prune always carries level zero
  a_prune_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !prune_active_r |-> (prune_level_r == '0))
    else $error("prune level set without active prune");

  // an enter against an empty table never starts probing
  a_empty_no_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.command == CMD_ENTER && count == '0) |=> (state_r != S_SEARCH))
    else $error("search started on empty table");

  // a pending result is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == S_FINISH) |=> $stable(out_data_r))
    else $error("stalled result overwritten");
`endif

endmodule
